### design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define SFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/sfp_pkg.sv
// shared types and constants of the frame parser
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 16;
  localparam int unsigned HDR_BYTES       = 6;
  localparam int unsigned FRAME_OVERHEAD  = 7;

  localparam logic [7:0] SYNC0      = 8'h55;
  localparam logic [7:0] SYNC1      = 8'hAA;
  localparam logic [7:0] CSUM_SEED  = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM,
    ST_DROP,
    ST_HDR,
    ST_EMIT,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } win_ctl_t;

endpackage

### design/serial_frame_parser_sum_checksum.sv
// top level: sync-header frame parser with 8-bit sum checksum
// sequence: a byte is taken, then the window is rescanned; a bad header drops a single byte,
//   a good one with a full frame behind it has its checksum summed, a good frame leaves
//   through the header, payload and tail states, a bad checksum drops seven window bytes
// input: one byte at a time; a byte is taken only once the rescan has stopped
// reset clears the byte count, the sequencer and out_valid; cell contents stay undefined
`timescale 1ns / 1ps
`include "assert_macros.svh"

module serial_frame_parser_sum_checksum import sfp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_command,
  output logic [4:0] out_payload_length,
  output logic [7:0] out_data_byte,
  output logic       out_data_valid,
  output logic       out_last
);

  localparam int unsigned DEPTH = MAX_PAYLOAD + FRAME_OVERHEAD;
  localparam int unsigned IDXW  = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned WW    = CW + 9;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IDXW-1:0] cnt_r, cnt_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [7:0]      cmd_r, cmd_nxt;
  logic [7:0]      len_r, len_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_cmd_r, out_cmd_nxt;
  logic [4:0]      out_len_r, out_len_nxt;
  logic [7:0]      out_data_r, out_data_nxt;
  logic            out_dv_r, out_dv_nxt;
  logic            out_last_r, out_last_nxt;

  win_ctl_t        ctl;
  logic [IDXW-1:0] load_idx;
  logic [7:0]      win_bytes [DEPTH];
  logic [IDXW-1:0] rd_idx;
  logic [7:0]      rd_byte;

  logic in_xfer, full, few, hdr_bad, short_win, cnt_at_len, csum_ok;
  logic out_free, emit_last;

  sfp_window #(.DEPTH(DEPTH)) u_window (
    .clk       (clk),
    .ctl       (ctl),
    .load_idx  (load_idx),
    .din       (in_rx_byte),
    .win_bytes (win_bytes)
  );

  assign in_ready   = (state_r == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign full       = (count_r == CW'(DEPTH));
  assign load_idx   = full ? IDXW'(DEPTH - 1) : count_r[IDXW-1:0];

  assign few        = (WW'(count_r) < WW'(FRAME_OVERHEAD));
  assign hdr_bad    = (win_bytes[0] != SYNC0) || (win_bytes[1] != SYNC1) ||
                      (win_bytes[4] != 8'h00) || (WW'(win_bytes[5]) > WW'(MAX_PAYLOAD));
  assign short_win  = (WW'(count_r) < (WW'(win_bytes[5]) + WW'(FRAME_OVERHEAD)));

  assign rd_idx     = IDXW'(HDR_BYTES) + cnt_r;
  assign rd_byte    = win_bytes[rd_idx];
  assign cnt_at_len = (WW'(cnt_r) == WW'(len_r));
  assign csum_ok    = (rd_byte == sum_r);

  assign out_free   = !out_valid_r || out_ready;
  assign emit_last  = (len_r == 8'h00) || (WW'(cnt_r) + WW'(1) == WW'(len_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (few || (!hdr_bad && short_win)) begin
          state_nxt = ST_IDLE;
        end else if (!hdr_bad) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (cnt_at_len) state_nxt = csum_ok ? ST_HDR : ST_DROP;
      end
      ST_DROP: begin
        if (cnt_r == IDXW'(FRAME_OVERHEAD - 1)) state_nxt = ST_SCAN;
      end
      ST_HDR: begin
        if (cnt_r == IDXW'(HDR_BYTES - 1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && emit_last) state_nxt = ST_TAIL;
      end
      ST_TAIL: state_nxt = ST_SCAN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and window control
  always_comb begin
    ctl           = '0;
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cmd_nxt   = out_cmd_r;
    out_len_nxt   = out_len_r;
    out_data_nxt  = out_data_r;
    out_dv_nxt    = out_dv_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ctl.load  = 1'b1;
          ctl.shift = full;
          count_nxt = full ? count_r : count_r + CW'(1);
        end
      end
      ST_SCAN: begin
        if (!few && hdr_bad) begin
          ctl.shift = 1'b1;
          count_nxt = count_r - CW'(1);
        end else if (!few && !short_win) begin
          cnt_nxt = '0;
          cmd_nxt = win_bytes[3];
          len_nxt = win_bytes[5];
          sum_nxt = CSUM_SEED + win_bytes[2] + win_bytes[3] + win_bytes[5];
        end
      end
      ST_SUM: begin
        if (cnt_at_len) begin
          cnt_nxt = '0;
        end else begin
          sum_nxt = sum_r + rd_byte;
          cnt_nxt = cnt_r + IDXW'(1);
        end
      end
      ST_DROP, ST_HDR: begin
        ctl.shift = 1'b1;
        count_nxt = count_r - CW'(1);
        cnt_nxt   = (state_nxt == state_r) ? cnt_r + IDXW'(1) : '0;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cmd_nxt   = cmd_r;
          out_len_nxt   = len_r[4:0];
          out_data_nxt  = (len_r == 8'h00) ? 8'h00 : win_bytes[0];
          out_dv_nxt    = (len_r != 8'h00);
          out_last_nxt  = emit_last;
          if (len_r != 8'h00) begin
            ctl.shift = 1'b1;
            count_nxt = count_r - CW'(1);
            cnt_nxt   = cnt_r + IDXW'(1);
          end
        end
      end
      ST_TAIL: begin
        ctl.shift = 1'b1;
        count_nxt = count_r - CW'(1);
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    cmd_r      <= cmd_nxt;
    len_r      <= len_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_len_r  <= out_len_nxt;
    out_data_r <= out_data_nxt;
    out_dv_r   <= out_dv_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_command        = out_cmd_r;
  assign out_payload_length = out_len_r;
  assign out_data_byte      = out_data_r;
  assign out_data_valid     = out_dv_r;
  assign out_last           = out_last_r;

  `SFP_ASSERT_ALWAYS(a_count_bound, !rst_n || (count_r <= CW'(DEPTH)), "count above depth")
  `SFP_ASSERT(a_short_idle, state_r == ST_SCAN && few |=> state_r == ST_IDLE, "scan not stopped")
  `SFP_ASSERT(a_sum_holds, (state_r == ST_SUM) |-> !few, "sum on short window")
  `SFP_ASSERT(a_take_scans, in_xfer |=> (state_r == ST_SCAN), "no scan after byte")

endmodule

### design/sfp_cell.sv
// one byte cell of the window chain
`timescale 1ns / 1ps

module sfp_cell import sfp_pkg::*; (
  input  logic       clk,
  input  win_ctl_t   ctl,
  input  logic       sel,
  input  logic [7:0] din,
  input  logic [7:0] nbr,
  output logic [7:0] q
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.load && sel) begin
      byte_nxt = din;
    end else if (ctl.shift) begin
      byte_nxt = nbr;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign q = byte_r;

endmodule

### design/sfp_window.sv
// window store built as a chain of byte cells shifting toward the front
`timescale 1ns / 1ps

module sfp_window import sfp_pkg::*; #(
  parameter int unsigned DEPTH = MAX_PAYLOAD_DEF + FRAME_OVERHEAD,
  localparam int unsigned IDXW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  win_ctl_t        ctl,
  input  logic [IDXW-1:0] load_idx,
  input  logic [7:0]      din,
  output logic [7:0]      win_bytes [DEPTH]
);

  logic [7:0] nbr [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_end
      assign nbr[g] = 8'h00;
    end else begin : g_mid
      assign nbr[g] = win_bytes[g+1];
    end

    sfp_cell u_cell (
      .clk (clk),
      .ctl (ctl),
      .sel (load_idx == IDXW'(g)),
      .din (din),
      .nbr (nbr[g]),
      .q   (win_bytes[g])
    );
  end

endmodule

### tb/sv/tb.sv
// testbench for the frame parser: byte stream driver, result monitor and frame predictor
`timescale 1ns / 1ps

module tb;
  import sfp_pkg::*;

  localparam int unsigned MAXP = MAX_PAYLOAD_DEF;
  localparam int unsigned WIN_DEPTH = MAXP + FRAME_OVERHEAD;
  localparam int unsigned RX_TARGET = 450;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 3 * WIN_DEPTH + 32;
  localparam int unsigned HOLD_CYCLES = 600;

  typedef struct packed {
    logic [7:0] command;
    logic [4:0] payload_length;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
  } frame_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_command;
  logic [4:0] out_payload_length;
  logic [7:0] out_data_byte;
  logic       out_data_valid;
  logic       out_last;

  serial_frame_parser_sum_checksum #(.MAX_PAYLOAD(MAXP)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_command        (out_command),
    .out_payload_length (out_payload_length),
    .out_data_byte      (out_data_byte),
    .out_data_valid     (out_data_valid),
    .out_last           (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [7:0]  rx_bytes_q[$];
  frame_item_t frame_items_q[$];
  logic [7:0]  win_bytes [WIN_DEPTH];
  int unsigned win_count = 0;
  int unsigned frames_good = 0;
  int unsigned csum_drops = 0;
  int unsigned bytes_sent = 0;
  int unsigned items_seen = 0;
  int unsigned fail_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          drv_idle;
  int unsigned idle_cycles = 0;
  frame_item_t got;

  task automatic shift_out(input int unsigned n);
    if (n >= win_count) begin
      win_count = 0;
    end else begin
      for (int i = 0; i < win_count - n; i++) win_bytes[i] = win_bytes[i + n];
      win_count -= n;
    end
  endtask

  // one received byte into the window, then rescan until nothing more can be removed
  task automatic parse_byte(input logic [7:0] b);
    logic [7:0]  sum;
    int unsigned len;
    bit          busy;
    frame_item_t it;
    if (win_count >= WIN_DEPTH) shift_out(1);
    win_bytes[win_count] = b;
    win_count++;
    busy = 1'b1;
    while (busy) begin
      if (win_count < FRAME_OVERHEAD) begin
        busy = 1'b0;
      end else if (win_bytes[0] != SYNC0 || win_bytes[1] != SYNC1) begin
        shift_out(1);
      end else if (win_bytes[4] != 8'h00 || win_bytes[5] > MAXP) begin
        shift_out(1);
      end else begin
        len = win_bytes[5];
        if (win_count < FRAME_OVERHEAD + len) begin
          busy = 1'b0;
        end else begin
          sum = CSUM_SEED + win_bytes[2] + win_bytes[3] + win_bytes[5];
          for (int i = 0; i < len; i++) sum += win_bytes[HDR_BYTES + i];
          if (sum != win_bytes[HDR_BYTES + len]) begin
            csum_drops++;
            shift_out(FRAME_OVERHEAD);
          end else begin
            frames_good++;
            if (len == 0) begin
              it = '{command: win_bytes[3], payload_length: 5'd0, data_byte: 8'h00,
                     data_valid: 1'b0, last: 1'b1};
              frame_items_q.push_back(it);
            end else begin
              for (int i = 0; i < len; i++) begin
                it = '{command: win_bytes[3], payload_length: 5'(len),
                       data_byte: win_bytes[HDR_BYTES + i], data_valid: 1'b1,
                       last: (i + 1 == len)};
                frame_items_q.push_back(it);
              end
            end
            shift_out(FRAME_OVERHEAD + len);
          end
        end
      end
    end
  endtask

  // queue the first keep bytes of a frame; csum_flip nonzero corrupts the checksum
  task automatic add_frame(input logic [7:0] ver, input logic [7:0] cmd, input int unsigned len,
                           input logic [7:0] csum_flip, input int unsigned keep);
    logic [7:0] fb[$];
    logic [7:0] sum;
    logic [7:0] d;
    fb.push_back(SYNC0);
    fb.push_back(SYNC1);
    fb.push_back(ver);
    fb.push_back(cmd);
    fb.push_back(8'h00);
    fb.push_back(8'(len));
    sum = CSUM_SEED + ver + cmd + 8'(len);
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      fb.push_back(d);
      sum += d;
    end
    fb.push_back(sum ^ csum_flip);
    for (int i = 0; i < fb.size() && i < keep; i++) rx_bytes_q.push_back(fb[i]);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_rx_byte);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        drv_idle = (bytes_sent < 150 || bytes_sent > 300) && ($urandom_range(0, 99) < 10);
        if (rx_bytes_q.size() != 0 && !drv_idle) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{command: out_command, payload_length: out_payload_length,
                data_byte: out_data_byte, data_valid: out_data_valid, last: out_last};
        if (frame_items_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transaction cmd=%h len=%0d data=%h dv=%b last=%b",
                   $time, got.command, got.payload_length, got.data_byte,
                   got.data_valid, got.last);
        end else if (got != frame_items_q[0]) begin
          fail_count++;
          $display("%0t: expected cmd=%h len=%0d data=%h dv=%b last=%b, got cmd=%h len=%0d data=%h dv=%b last=%b",
                   $time, frame_items_q[0].command, frame_items_q[0].payload_length,
                   frame_items_q[0].data_byte, frame_items_q[0].data_valid,
                   frame_items_q[0].last, got.command, got.payload_length, got.data_byte,
                   got.data_valid, got.last);
          void'(frame_items_q.pop_front());
        end else begin
          void'(frame_items_q.pop_front());
        end
        items_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && items_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (items_seen >= 100 && items_seen < 200) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned len;
    // empty frame, extreme version and command
    add_frame(8'h00, 8'hFF, 0, 8'h00, 32);
    // bad checksum around a good empty frame: the data bytes survive the drop
    rx_bytes_q.push_back(SYNC0);
    rx_bytes_q.push_back(SYNC1);
    rx_bytes_q.push_back(8'h01);
    rx_bytes_q.push_back(8'h02);
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'h07);
    add_frame(8'hFF, 8'h12, 0, 8'h00, 32);
    rx_bytes_q.push_back(8'hD4);
    // nonzero length high byte
    rx_bytes_q.push_back(SYNC0);
    rx_bytes_q.push_back(SYNC1);
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'h01);
    rx_bytes_q.push_back(8'h00);

    while (rx_bytes_q.size() < RX_TARGET) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(5, MAXP);
      if (pick < 60) begin
        add_frame(8'($urandom), 8'($urandom), len, 8'h00, 32);
      end else if (pick < 70) begin
        add_frame(8'($urandom), 8'($urandom), len, 8'($urandom_range(1, 255)), 32);
      end else if (pick < 78) begin
        rx_bytes_q.push_back(SYNC0);
        rx_bytes_q.push_back(SYNC1);
        rx_bytes_q.push_back(8'($urandom));
        rx_bytes_q.push_back(8'($urandom));
        rx_bytes_q.push_back(8'($urandom_range(1, 255)));
        rx_bytes_q.push_back(8'($urandom_range(0, MAXP)));
      end else if (pick < 86) begin
        rx_bytes_q.push_back(SYNC0);
        rx_bytes_q.push_back(SYNC1);
        rx_bytes_q.push_back(8'($urandom));
        rx_bytes_q.push_back(8'($urandom));
        rx_bytes_q.push_back(8'h00);
        rx_bytes_q.push_back(8'($urandom_range(MAXP + 1, 255)));
      end else if (pick < 94) begin
        for (int i = $urandom_range(1, 5); i > 0; i--) begin
          rx_bytes_q.push_back(($urandom_range(0, 3) == 0) ? SYNC0 : 8'($urandom));
        end
      end else begin
        add_frame(8'($urandom), 8'($urandom), len, 8'h00, $urandom_range(1, len + 6));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (rx_bytes_q.size() != 0 || in_valid || frame_items_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d rx bytes: %0d good frames, %0d checksum drops, %0d frame items checked",
             bytes_sent, frames_good, csum_drops, items_seen);
    $display("random idling on both sides, one receiver hold-off of %0d cycles", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
